>>> hw/rtl/hpid_pkg.sv
// hpid_pkg: shared types and constants for the heading pid turn controller
// stage payload structs, register indexes, reset values and fixed-point limits
// no dependencies
`default_nettype none

package hpid_pkg;

  localparam int NUM_STAGES = 6;

  // request codes
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_GAIN_P       = 2'd0,
    CFG_GAIN_I       = 2'd1,
    CFG_GAIN_D       = 2'd2,
    CFG_SAMPLE_LIMIT = 2'd3
  } cfg_idx_t;

  localparam logic [31:0] GAIN_P_RST       = 32'd6710886;
  localparam logic [31:0] GAIN_I_RST       = 32'd671;
  localparam logic [31:0] GAIN_D_RST       = 32'd1677722;
  localparam logic [9:0]  SAMPLE_LIMIT_RST = 10'd50;

  localparam logic signed [24:0] ERR_MAX = {1'b0, {24{1'b1}}};
  localparam logic signed [24:0] ERR_MIN = {1'b1, {24{1'b0}}};
  localparam logic signed [39:0] SUM_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] SUM_MIN = {1'b1, {39{1'b0}}};

  // integral term magnitude limit, 2^60
  localparam logic signed [72:0] TERM_LIM     = 73'sd1152921504606846976;
  localparam logic signed [72:0] TERM_LIM_NEG = -TERM_LIM;

  // divide by 30*2^24 as shift by 25 then divide by 15
  localparam int          DIV_SHIFT = 25;
  localparam logic [37:0] SAT_M     = 38'd491520;   // 15 * 32768
  localparam logic [19:0] RECIP_15  = 20'd559241;   // ceil(2^23 / 15)
  localparam int          RECIP_SH  = 23;

  localparam logic signed [15:0] DRIVE_MAX  = 16'sd32767;
  localparam logic signed [15:0] DRIVE_MIN  = -16'sd32768;
  localparam logic signed [15:0] DRIVE_NMAX = -16'sd32767;

  typedef struct packed {
    logic              run;
    logic              done;
    logic signed [24:0] err;
    logic signed [25:0] dlt;
    logic signed [39:0] sum;
  } front_t;

  typedef struct packed {
    logic              run;
    logic              done;
    logic signed [57:0] prod_p;
    logic signed [58:0] prod_d;
    logic signed [52:0] prod_ih;
    logic        [51:0] prod_il;
  } mult_t;

  typedef struct packed {
    logic              run;
    logic              done;
    logic signed [59:0] pd_sum;
    logic signed [61:0] i_term;
  } term_t;

  typedef struct packed {
    logic              run;
    logic              done;
    logic signed [62:0] total;
  } total_t;

  typedef struct packed {
    logic        run;
    logic        done;
    logic        neg;
    logic        sat;
    logic [18:0] m;
  } quot_t;

endpackage

`default_nettype wire

>>> hw/rtl/hpid_front.sv
// hpid_front: turn state (target, integral, last error, sample count) and stage one
// forms error, delta and saturated integral for each accepted word
// depends on hpid_pkg
`default_nettype none

module hpid_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic                 load,
  input  wire logic                 req_type,
  input  wire logic signed [23:0]   angle,
  input  wire logic signed [23:0]   turn,
  input  wire logic        [9:0]    sample_limit,
  output hpid_pkg::front_t          stage_r
);

  logic signed [24:0] target_r, target_nxt;
  logic signed [39:0] sum_r, sum_nxt;
  logic signed [24:0] last_r, last_nxt;
  logic        [9:0]  count_r, count_nxt;
  logic               active_r, active_nxt;

  logic signed [25:0] diff;
  logic signed [24:0] err;
  logic signed [25:0] dlt;
  logic signed [40:0] sum_w;
  logic signed [39:0] sum_sat;
  logic               is_start;
  logic               below;
  hpid_pkg::front_t   stage_nxt;

  always_comb begin
    is_start = (req_type == hpid_pkg::REQ_START);
    below    = (count_r < sample_limit);

    diff = {target_r[24], target_r} - {{2{angle[23]}}, angle};
    if (diff[25] != diff[24]) begin
      err = diff[25] ? hpid_pkg::ERR_MIN : hpid_pkg::ERR_MAX;
    end else begin
      err = diff[24:0];
    end
    dlt = {err[24], err} - {last_r[24], last_r};

    sum_w = {sum_r[39], sum_r} + {{16{err[24]}}, err};
    if (sum_w[40] != sum_w[39]) begin
      sum_sat = sum_w[40] ? hpid_pkg::SUM_MIN : hpid_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_w[39:0];
    end

    stage_nxt.run  = !is_start && active_r && below;
    stage_nxt.done = !is_start && active_r && !below;
    stage_nxt.err  = err;
    stage_nxt.dlt  = dlt;
    stage_nxt.sum  = sum_sat;

    target_nxt = target_r;
    sum_nxt    = sum_r;
    last_nxt   = last_r;
    count_nxt  = count_r;
    active_nxt = active_r;
    if (accept) begin
      if (is_start) begin
        target_nxt = {angle[23], angle} + {turn[23], turn};
        sum_nxt    = '0;
        count_nxt  = '0;
        active_nxt = 1'b1;
      end else if (stage_nxt.run) begin
        sum_nxt   = sum_sat;
        last_nxt  = err;
        count_nxt = count_r + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      sum_r    <= '0;
      last_r   <= '0;
      count_r  <= '0;
      active_r <= 1'b0;
    end else begin
      target_r <= target_nxt;
      sum_r    <= sum_nxt;
      last_r   <= last_nxt;
      count_r  <= count_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hpid_gain.sv
// hpid_gain: gain products (stage two) and clamped integral term plus p/d sum (stage three)
// integral product split into two 20 bit halves of the error sum
// depends on hpid_pkg
`default_nettype none

module hpid_gain (
  input  wire logic              clk,
  input  wire logic              load_mul,
  input  wire logic              load_term,
  input  wire hpid_pkg::front_t  front_i,
  input  wire logic [31:0]       gain_p,
  input  wire logic [31:0]       gain_i,
  input  wire logic [31:0]       gain_d,
  output hpid_pkg::term_t        term_r
);

  hpid_pkg::mult_t    mult_r, mult_nxt;
  hpid_pkg::term_t    term_nxt;
  logic signed [32:0] gp_s, gi_s, gd_s;
  logic signed [72:0] i_full;

  always_comb begin
    gp_s = {1'b0, gain_p};
    gi_s = {1'b0, gain_i};
    gd_s = {1'b0, gain_d};
    mult_nxt.run     = front_i.run;
    mult_nxt.done    = front_i.done;
    mult_nxt.prod_p  = gp_s * front_i.err;
    mult_nxt.prod_d  = gd_s * front_i.dlt;
    mult_nxt.prod_ih = gi_s * $signed(front_i.sum[39:20]);
    mult_nxt.prod_il = gain_i * front_i.sum[19:0];
  end

  always_comb begin
    i_full = {mult_r.prod_ih, 20'd0} + {21'd0, mult_r.prod_il};
    term_nxt.run    = mult_r.run;
    term_nxt.done   = mult_r.done;
    term_nxt.pd_sum = {{2{mult_r.prod_p[57]}}, mult_r.prod_p}
                    + {mult_r.prod_d[58], mult_r.prod_d};
    if (i_full > hpid_pkg::TERM_LIM) begin
      term_nxt.i_term = hpid_pkg::TERM_LIM[61:0];
    end else if (i_full < hpid_pkg::TERM_LIM_NEG) begin
      term_nxt.i_term = hpid_pkg::TERM_LIM_NEG[61:0];
    end else begin
      term_nxt.i_term = i_full[61:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_mul) begin
      mult_r <= mult_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_term) begin
      term_r <= term_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hpid_scale.sv
// hpid_scale: total sum, divide by 30*2^24 toward zero, saturation and drive output register
// stages four to six; divide by 15 through a reciprocal multiply
// depends on hpid_pkg
`default_nettype none

module hpid_scale (
  input  wire logic              clk,
  input  wire logic              load_total,
  input  wire logic              load_quot,
  input  wire logic              load_out,
  input  wire hpid_pkg::term_t   term_i,
  output logic signed [15:0]     left_r,
  output logic signed [15:0]     right_r,
  output logic                   done_r
);

  hpid_pkg::total_t   total_r, total_nxt;
  hpid_pkg::quot_t    quot_r, quot_nxt;
  logic        [62:0] mag;
  logic        [37:0] m_hi;
  logic        [38:0] prod;
  logic signed [15:0] q;
  logic signed [15:0] left_nxt, right_nxt;
  logic               done_nxt;

  always_comb begin
    total_nxt.run   = term_i.run;
    total_nxt.done  = term_i.done;
    total_nxt.total = {{3{term_i.pd_sum[59]}}, term_i.pd_sum}
                    + {term_i.i_term[61], term_i.i_term};
  end

  always_comb begin
    quot_nxt.run  = total_r.run;
    quot_nxt.done = total_r.done;
    quot_nxt.neg  = total_r.total[62];
    mag  = total_r.total[62] ? (63'd0 - total_r.total) : total_r.total;
    m_hi = mag[62:hpid_pkg::DIV_SHIFT];
    quot_nxt.sat = (m_hi >= hpid_pkg::SAT_M);
    quot_nxt.m   = m_hi[18:0];
  end

  always_comb begin
    prod = quot_r.m * hpid_pkg::RECIP_15;
    q    = prod[38:hpid_pkg::RECIP_SH];
    if (!quot_r.run) begin
      left_nxt  = '0;
      right_nxt = '0;
      done_nxt  = quot_r.done;
    end else begin
      done_nxt = 1'b0;
      if (quot_r.sat) begin
        left_nxt  = quot_r.neg ? hpid_pkg::DRIVE_MIN : hpid_pkg::DRIVE_MAX;
        right_nxt = quot_r.neg ? hpid_pkg::DRIVE_MAX : hpid_pkg::DRIVE_NMAX;
      end else begin
        left_nxt  = quot_r.neg ? (16'sd0 - q) : q;
        right_nxt = quot_r.neg ? q : (16'sd0 - q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_total) begin
      total_r <= total_nxt;
    end
    if (load_quot) begin
      quot_r <= quot_nxt;
    end
    if (load_out) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/heading_pid_turn_controller_core.sv
// heading_pid_turn_controller_core: top level of the heading pid turn controller
// holds the gain registers and the pipeline handshake; uses hpid_pkg, hpid_front,
// hpid_gain and hpid_scale
//
// Six-stage pipeline taking one word per clock: the turn state (target, integral,
// last error, sample count) updates in the cycle a word is accepted, so back to back
// samples see each other's effect, and each result passes through the front, product,
// term, total, quotient and output registers. Every stage holds its own valid bit, so
// bubbles close up while a result waits and in_ready drops only when all six stages
// are full and out_ready is low. Gain and limit registers are written through the cfg
// port, which is always ready, and must only change while no words are in flight.
`default_nettype none

module heading_pid_turn_controller_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req_type,
  input  wire logic signed [23:0] in_angle,
  input  wire logic signed [23:0] in_turn,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_left_drive,
  output logic signed [15:0]      out_right_drive,
  output logic                    out_done_res,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int NS = hpid_pkg::NUM_STAGES;

  logic [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [9:0]  limit_r;
  logic [NS:1] valid_r, valid_nxt, feed, go;
  logic        accept;

  hpid_pkg::front_t front;
  hpid_pkg::term_t  term;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= hpid_pkg::GAIN_P_RST;
      gain_i_r <= hpid_pkg::GAIN_I_RST;
      gain_d_r <= hpid_pkg::GAIN_D_RST;
      limit_r  <= hpid_pkg::SAMPLE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (hpid_pkg::cfg_idx_t'(cfg_index))
        hpid_pkg::CFG_GAIN_P:       gain_p_r <= cfg_data;
        hpid_pkg::CFG_GAIN_I:       gain_i_r <= cfg_data;
        hpid_pkg::CFG_GAIN_D:       gain_d_r <= cfg_data;
        hpid_pkg::CFG_SAMPLE_LIMIT: limit_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // per-stage valid and advance
  assign feed = {valid_r[NS-1:1], in_valid};

  always_comb begin
    go[NS] = out_ready | ~valid_r[NS];
    for (int k = NS - 1; k >= 1; k--) begin
      go[k] = go[k+1] | ~valid_r[k];
    end
    valid_nxt = valid_r;
    for (int k = 1; k <= NS; k++) begin
      if (go[k]) begin
        valid_nxt[k] = feed[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = go[1];
  assign accept    = in_valid & go[1];
  assign out_valid = valid_r[NS];

  hpid_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .load         (go[1]),
    .req_type     (in_req_type),
    .angle        (in_angle),
    .turn         (in_turn),
    .sample_limit (limit_r),
    .stage_r      (front)
  );

  hpid_gain u_gain (
    .clk       (clk),
    .load_mul  (go[2]),
    .load_term (go[3]),
    .front_i   (front),
    .gain_p    (gain_p_r),
    .gain_i    (gain_i_r),
    .gain_d    (gain_d_r),
    .term_r    (term)
  );

  hpid_scale u_scale (
    .clk        (clk),
    .load_total (go[4]),
    .load_quot  (go[5]),
    .load_out   (go[6]),
    .term_i     (term),
    .left_r     (out_left_drive),
    .right_r    (out_right_drive),
    .done_r     (out_done_res)
  );

endmodule

`default_nettype wire
